### rtl/tmrf_pkg.sv
// Shared types and constants for the tandem motif run finder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tmrf_pkg;

    localparam int BASE_BITS     = 3;
    localparam int LEN_BITS      = 5;
    localparam int MOTIF_BITS    = 32;
    localparam int OUT_BITS      = 32;
    localparam int WIN_LIMIT     = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int DEF_MAX_MOTIF = 16;
    localparam int DEF_POS_BITS  = 32;
    localparam int Q_DEPTH       = 4;

    // Reset value of the motif is TTAGGG, first base in the lowest bits.
    localparam logic [MOTIF_BITS-1:0] MOTIF_RESET = 32'd2703;
    localparam logic [LEN_BITS-1:0]   LEN_RESET   = 5'd6;

    typedef logic [OUT_BITS-1:0]  t_word;
    typedef logic [BASE_BITS-1:0] t_base;
    typedef logic [LEN_BITS-1:0]  t_len;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MOTIF_BASES  = 1'b0,
        REG_MOTIF_LENGTH = 1'b1
    } t_cfg_reg;

    // What one strand tracker reports for the base under evaluation.
    typedef struct packed {
        logic emit;   // a run closes on this base
        logic flush;  // the run closes because the record ends
    } t_strand_ev;

endpackage

### rtl/tmrf_cell.sv
// One cell of the base window: holds one base, passes it on, and compares it.
// Depends on tmrf_pkg.
`timescale 1ns / 1ps

module tmrf_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_shift,
    input  tmrf_pkg::t_base                     i_base,
    input  tmrf_pkg::t_len                      i_len,
    input  logic [tmrf_pkg::MOTIF_BITS-1:0]     i_motif,
    output tmrf_pkg::t_base                     o_base,
    output logic                                o_fwd_eq,
    output logic                                o_rev_eq
);
    import tmrf_pkg::*;

    t_base        r_base;
    logic [4:0]   w_idx_full;
    logic [3:0]   w_idx;
    logic         w_used;
    logic         w_known;
    logic [1:0]   w_fwd_ref;
    logic [1:0]   w_rev_ref;

    // The window carries no reset; entries are only read once written.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_base <= i_base;
        end
    end

    assign o_base = r_base;

    // Cell IDX sits against motif base len-1-IDX on the forward strand and
    // against the complement of motif base IDX on the reverse strand.
    assign w_used     = (LEN_BITS'(IDX) < i_len);
    assign w_idx_full = i_len - LEN_BITS'(IDX + 1);
    assign w_idx      = w_idx_full[3:0];
    assign w_known    = (r_base <= BASE_BITS'(3));
    assign w_fwd_ref  = i_motif[{w_idx, 1'b0} +: 2];
    assign w_rev_ref  = ~i_motif[2*IDX +: 2];

    assign o_fwd_eq = !w_used || (w_known && (r_base[1:0] == w_fwd_ref));
    assign o_rev_eq = !w_used || (w_known && (r_base[1:0] == w_rev_ref));

endmodule

### rtl/tmrf_strand.sv
// Run tracker for one strand: start search, copy checks, run closing.
// Depends on tmrf_pkg.
`timescale 1ns / 1ps

module tmrf_strand #(
    parameter int POS_BITS = tmrf_pkg::DEF_POS_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic                   i_step_en,
    input  tmrf_pkg::t_len         i_len,
    input  logic [POS_BITS-1:0]    i_pos,
    input  logic                   i_match,
    input  logic                   i_record_end,
    output tmrf_pkg::t_strand_ev   o_ev,
    output logic [POS_BITS-1:0]    o_start,
    output logic [POS_BITS-1:0]    o_end
);
    import tmrf_pkg::*;

    logic                r_in_run,      n_in_run;
    logic [POS_BITS-1:0] r_run_start,   n_run_start;
    logic [POS_BITS-1:0] r_next_copy,   n_next_copy;
    logic [POS_BITS-1:0] r_search_from, n_search_from;

    logic [POS_BITS-1:0] w_len;
    logic [POS_BITS-1:0] w_first;
    logic [POS_BITS-1:0] w_check_pos;
    logic                w_step_emit;

    assign w_len       = POS_BITS'(i_len);
    assign w_first     = i_pos - (w_len - POS_BITS'(1));
    assign w_check_pos = r_next_copy + w_len - POS_BITS'(1);

    always_comb begin
        n_in_run      = r_in_run;
        n_run_start   = r_run_start;
        n_next_copy   = r_next_copy;
        n_search_from = r_search_from;
        w_step_emit   = 1'b0;

        if (i_step_en) begin
            if (r_in_run) begin
                if (i_pos == w_check_pos) begin
                    if (i_match) begin
                        n_next_copy = r_next_copy + w_len;
                    end else begin
                        w_step_emit   = 1'b1;
                        n_search_from = r_next_copy + POS_BITS'(1);
                        n_in_run      = 1'b0;
                    end
                end
            end else if ((w_first >= r_search_from) && i_match) begin
                n_in_run    = 1'b1;
                n_run_start = w_first;
                n_next_copy = w_first + w_len;
            end
        end

        // The reported bounds are those after this base's copy check.
        o_start    = n_run_start;
        o_end      = n_next_copy;
        o_ev.flush = i_record_end && n_in_run;
        o_ev.emit  = w_step_emit || o_ev.flush;

        if (i_record_end) begin
            n_in_run      = 1'b0;
            n_search_from = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run      <= 1'b0;
            r_run_start   <= '0;
            r_next_copy   <= '0;
            r_search_from <= '0;
        end else if (i_go) begin
            r_in_run      <= n_in_run;
            r_run_start   <= n_run_start;
            r_next_copy   <= n_next_copy;
            r_search_from <= n_search_from;
        end
    end

endmodule

### rtl/tmrf_outq.sv
// Result queue: each entry holds the one or two reports of one base,
// delivered one per transfer. Depends on tmrf_pkg.
`timescale 1ns / 1ps

module tmrf_outq #(
    parameter int DEPTH  = tmrf_pkg::Q_DEPTH,
    parameter int SLOT_W = 2 * tmrf_pkg::DEF_POS_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_two,
    input  logic [SLOT_W-1:0]            i_slot0,
    input  logic [SLOT_W-1:0]            i_slot1,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [SLOT_W-1:0]            o_slot,
    output logic                         o_last,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    import tmrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);
    localparam int ENT_W = 2 * SLOT_W + 1;

    logic [ENT_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0]  r_level,  n_level;
    logic              r_sub,    n_sub;
    logic [ENT_W-1:0]  w_head;
    logic              w_pop;

    assign w_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_level != '0);
    assign o_slot  = r_sub ? w_head[2*SLOT_W-1:SLOT_W] : w_head[SLOT_W-1:0];
    assign o_last  = !w_head[ENT_W-1] || r_sub;
    assign o_level = r_level;

    // An entry leaves the queue only after its final report is transferred.
    assign w_pop = o_valid && !i_stall && o_last;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        n_sub    = r_sub;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (o_valid && !i_stall) begin
            n_sub = !o_last;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, w_pop})
            2'b10:   n_level = r_level + LVL_W'(1);
            2'b01:   n_level = r_level - LVL_W'(1);
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= {i_two, i_slot1, i_slot0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
            r_sub    <= n_sub;
        end
    end

endmodule

### rtl/tandem_motif_run_finder_top.sv
// Top level of the tandem motif run finder: base window chain, two strand
// trackers and the result queue. Depends on tmrf_pkg, tmrf_cell,
// tmrf_strand and tmrf_outq.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one coded base per transfer
//   plus a record-end flag on the last base of each record. Output channel
//   (o_valid / i_stall) carries one run report per transfer: strand, start,
//   end, length and a flag on the final report caused by a given base.
//   The configuration channel (i_cfg_valid / o_cfg_ready) writes the motif
//   (index 0) and its length (index 1); it is always ready and should only
//   be used while no base is in flight.
//   Throughput is one base per cycle while o_stall is low. A base that is
//   transferred shifts into the window, is evaluated in the following
//   cycle, and its reports are registered into the result queue, which
//   offers them on the output. A base that closes runs on both strands
//   yields two reports on consecutive transfers.
//   When the receiver stalls, reports wait in a four-entry queue; the input
//   stalls only once the queue, counting the base under evaluation, is full.
//   Synchronous reset empties the queue, clears open runs, position and
//   search starts, and restores the TTAGGG motif of length six.
`timescale 1ns / 1ps

module tandem_motif_run_finder_top #(
    parameter int MAX_MOTIF = tmrf_pkg::DEF_MAX_MOTIF,
    parameter int POS_BITS  = tmrf_pkg::DEF_POS_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Base input channel.
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [tmrf_pkg::BASE_BITS-1:0]        i_base_code,
    input  logic                                  i_record_end,
    // Report output channel.
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_strand,
    output logic [tmrf_pkg::OUT_BITS-1:0]         o_run_start,
    output logic [tmrf_pkg::OUT_BITS-1:0]         o_run_end,
    output logic [tmrf_pkg::OUT_BITS-1:0]         o_run_length,
    output logic                                  o_last_result,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tmrf_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tmrf_pkg::MOTIF_BITS-1:0]       i_cfg_data
);
    import tmrf_pkg::*;

    // The window never holds more bases than the motif register can describe.
    localparam int WIN_DEPTH = (MAX_MOTIF < WIN_LIMIT) ? MAX_MOTIF : WIN_LIMIT;
    localparam int SLOT_W    = 2 * POS_BITS + 1;
    localparam int LVL_W     = $clog2(Q_DEPTH + 1);

    logic [MOTIF_BITS-1:0] r_motif;
    t_len                  r_motif_len;
    t_len                  w_len;

    logic                  w_accept;
    logic                  r_pend;
    logic                  r_pend_end;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic                  w_step_en;

    t_base                 w_chain   [WIN_DEPTH+1];
    logic [WIN_DEPTH-1:0]  w_fwd_eq;
    logic [WIN_DEPTH-1:0]  w_rev_eq;

    t_strand_ev            w_fwd_ev, w_rev_ev;
    logic [POS_BITS-1:0]   w_fwd_start, w_fwd_end;
    logic [POS_BITS-1:0]   w_rev_start, w_rev_end;

    logic [SLOT_W-1:0]     w_fwd_slot, w_rev_slot;
    logic [SLOT_W-1:0]     w_slot0, w_slot1;
    logic                  w_push, w_two;
    logic [SLOT_W-1:0]     w_out_slot;
    logic [LVL_W-1:0]      w_level;
    logic [POS_BITS-1:0]   w_out_start, w_out_end, w_out_len;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif     <= MOTIF_RESET;
            r_motif_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MOTIF_BASES:  r_motif     <= i_cfg_data;
                REG_MOTIF_LENGTH: r_motif_len <= i_cfg_data[LEN_BITS-1:0];
                default:          r_motif     <= r_motif;
            endcase
        end
    end

    // Lengths beyond the window saturate; zero means nothing ever matches.
    assign w_len = (r_motif_len > LEN_BITS'(WIN_DEPTH)) ? LEN_BITS'(WIN_DEPTH)
                                                        : r_motif_len;

    // ------------------------------------------------------------------
    // Input side. The base under evaluation always finishes in the next
    // cycle, so the only back pressure is room in the result queue.
    // ------------------------------------------------------------------
    assign o_stall  = (32'(w_level) + 32'(r_pend)) >= Q_DEPTH;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_end <= i_record_end;
        end
    end

    // ------------------------------------------------------------------
    // Base window: a chain of cells, newest base in cell zero. Each cell
    // compares its base against the motif and its reverse complement.
    // ------------------------------------------------------------------
    assign w_chain[0] = i_base_code;

    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
        tmrf_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_accept),
            .i_base   (w_chain[g]),
            .i_len    (w_len),
            .i_motif  (r_motif),
            .o_base   (w_chain[g+1]),
            .o_fwd_eq (w_fwd_eq[g]),
            .o_rev_eq (w_rev_eq[g])
        );
    end

    // ------------------------------------------------------------------
    // Position counter and match gating. Matching only begins once a whole
    // motif of the current record has entered the window.
    // ------------------------------------------------------------------
    assign w_step_en = r_pend && (w_len != '0) &&
                       (r_pos >= (POS_BITS'(w_len) - POS_BITS'(1)));

    assign n_pos = r_pend_end ? '0 : r_pos + POS_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (r_pend) begin
            r_pos <= n_pos;
        end
    end

    tmrf_strand #(
        .POS_BITS (POS_BITS)
    ) u_fwd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (r_pend),
        .i_step_en    (w_step_en),
        .i_len        (w_len),
        .i_pos        (r_pos),
        .i_match      (&w_fwd_eq),
        .i_record_end (r_pend_end),
        .o_ev         (w_fwd_ev),
        .o_start      (w_fwd_start),
        .o_end        (w_fwd_end)
    );

    tmrf_strand #(
        .POS_BITS (POS_BITS)
    ) u_rev (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (r_pend),
        .i_step_en    (w_step_en),
        .i_len        (w_len),
        .i_pos        (r_pos),
        .i_match      (&w_rev_eq),
        .i_record_end (r_pend_end),
        .o_ev         (w_rev_ev),
        .o_start      (w_rev_start),
        .o_end        (w_rev_end)
    );

    // ------------------------------------------------------------------
    // Report ordering. Copy-check failures come before record-end flushes,
    // forward before reverse within each kind. So a reverse failure goes
    // ahead of a forward flush on the same base.
    // ------------------------------------------------------------------
    assign w_fwd_slot = {1'b0, w_fwd_end, w_fwd_start};
    assign w_rev_slot = {1'b1, w_rev_end, w_rev_start};

    always_comb begin
        w_push  = r_pend && (w_fwd_ev.emit || w_rev_ev.emit);
        w_two   = w_fwd_ev.emit && w_rev_ev.emit;
        w_slot0 = w_fwd_ev.emit ? w_fwd_slot : w_rev_slot;
        w_slot1 = w_rev_slot;
        if (w_two && w_fwd_ev.flush && !w_rev_ev.flush) begin
            w_slot0 = w_rev_slot;
            w_slot1 = w_fwd_slot;
        end
    end

    tmrf_outq #(
        .DEPTH  (Q_DEPTH),
        .SLOT_W (SLOT_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_two   (w_two),
        .i_slot0 (w_slot0),
        .i_slot1 (w_slot1),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_slot  (w_out_slot),
        .o_last  (o_last_result),
        .o_level (w_level)
    );

    // Positions wrap at POS_BITS; the ports show their low 32 bits.
    assign w_out_start = w_out_slot[POS_BITS-1:0];
    assign w_out_end   = w_out_slot[2*POS_BITS-1:POS_BITS];
    assign w_out_len   = w_out_end - w_out_start;

    assign o_strand     = w_out_slot[SLOT_W-1];
    assign o_run_start  = t_word'(w_out_start);
    assign o_run_end    = t_word'(w_out_end);
    assign o_run_length = t_word'(w_out_len);

endmodule

### rtl/tmrf_checker.sv
// Port-level checks for the tandem motif run finder and their binding.
// Depends on tmrf_pkg and tandem_motif_run_finder_top.
`timescale 1ns / 1ps

module tmrf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_stall,
    input logic                          o_valid,
    input logic                          o_strand,
    input logic [tmrf_pkg::OUT_BITS-1:0] o_run_start,
    input logic [tmrf_pkg::OUT_BITS-1:0] o_run_end,
    input logic [tmrf_pkg::OUT_BITS-1:0] o_run_length,
    input logic                          o_last_result
);
    import tmrf_pkg::*;

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("report offered right after reset");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("report withdrawn while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_strand, o_run_start, o_run_end,
                                        o_run_length, o_last_result}))
        else $error("report changed while stalled");

    // A base closes at most one run per strand, so the two reports of one
    // base follow each other at once and name different strands.
    a_pair_strands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_result |=>
            o_valid && (o_strand != $past(o_strand)))
        else $error("paired reports broken or on the same strand");

endmodule

bind tandem_motif_run_finder_top tmrf_checker u_tmrf_checker (.*);

### tb/tandem_motif_run_finder_top_tb.sv
// Self-checking testbench for tandem_motif_run_finder_top: directed and random base
// streams, a run predictor, and bursty input with receiver stalls.
// Depends on tmrf_pkg and the tandem_motif_run_finder_top RTL.
`timescale 1ns / 1ps

module tandem_motif_run_finder_top_tb;

    import tmrf_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    // Idle cycles after the last report before the registers are touched again,
    // ample for a pending base to drain.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 155;
    localparam int MOTIF_CAP     = (DEF_MAX_MOTIF < WIN_LIMIT) ? DEF_MAX_MOTIF : WIN_LIMIT;

    typedef struct {
        t_base code;
        logic  rec_end;
    } t_base_item;

    typedef struct {
        logic  strand;
        t_word run_start;
        t_word run_end;
        t_word run_length;
        logic  last_result;
    } t_run_report;

    // Block ports. Every input holds a known value from time zero.
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic                    o_stall;
    t_base                   i_base_code  = '0;
    logic                    i_record_end = 1'b0;
    logic                    o_valid;
    logic                    i_stall      = 1'b0;
    logic                    o_strand;
    t_word                   o_run_start;
    t_word                   o_run_end;
    t_word                   o_run_length;
    logic                    o_last_result;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index  = '0;
    logic [MOTIF_BITS-1:0]   i_cfg_data   = '0;

    tandem_motif_run_finder_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_base_code  (i_base_code),
        .i_record_end (i_record_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_strand     (o_strand),
        .o_run_start  (o_run_start),
        .o_run_end    (o_run_end),
        .o_run_length (o_run_length),
        .o_last_result(o_last_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Run predictor state: its own copy of the registers, the base history
    // and one tracker per strand (index 0 forward, index 1 reverse
    // complement).
    // ------------------------------------------------------------------
    logic [MOTIF_BITS-1:0]   cfg_motif  = MOTIF_RESET;
    t_len                    cfg_length = LEN_RESET;
    t_base                   win_hist [WIN_LIMIT];
    logic [DEF_POS_BITS-1:0] base_pos;
    logic                    trk_open  [2];
    logic [DEF_POS_BITS-1:0] trk_start [2];
    logic [DEF_POS_BITS-1:0] trk_next  [2];
    logic [DEF_POS_BITS-1:0] trk_from  [2];

    t_run_report fresh_runs[$];     // reports caused by the base being predicted
    t_run_report runs_expected[$];  // reports the block still owes us
    t_base_item  base_queue[$];     // bases waiting for the driver
    t_base       record_bases[$];   // record under construction

    logic [31:0] cycle_count = '0;
    int unsigned errors       = 0;
    int unsigned bases_sent   = 0;
    int unsigned reports_seen = 0;

    // Lengths beyond the window or the motif limit saturate; zero disables matching.
    function automatic int unsigned motif_span();
        int unsigned len;
        len = cfg_length;
        if (len > MOTIF_CAP) begin
            len = MOTIF_CAP;
        end
        return len;
    endfunction

    // Compares the newest len bases against the motif. The oldest base of the
    // window lines up with the first motif base going forward; for the
    // reverse complement each window slot matches the complement of the
    // motif base with the same index.
    function automatic logic window_hit(int unsigned len, logic rev);
        t_base      b;
        logic [1:0] m;
        for (int i = 0; i < len; i++) begin
            b = win_hist[len-1-i];
            if (b > 3) begin
                return 1'b0;
            end
            if (rev) begin
                m = 2'd3 - cfg_motif[2*(len-1-i) +: 2];
            end else begin
                m = cfg_motif[2*i +: 2];
            end
            if (b[1:0] != m) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_run_report make_report(logic st, logic [31:0] s, logic [31:0] e);
        t_run_report r;
        r.strand      = st;
        r.run_start   = s;
        r.run_end     = e;
        r.run_length  = e - s;
        r.last_result = 1'b0;
        return r;
    endfunction

    // One strand: either extend or close an open run when its next copy is
    // complete, or open a new run at or after the search start. A run that
    // closes on this base cannot reopen on the same base.
    task automatic track_strand(int st, int unsigned len, logic [31:0] p);
        logic [31:0] s;
        logic        rev;
        s   = p - (len - 1);
        rev = (st != 0);
        if (trk_open[st]) begin
            if (p == trk_next[st] + len - 1) begin
                if (window_hit(len, rev)) begin
                    trk_next[st] = trk_next[st] + len;
                end else begin
                    fresh_runs.push_back(make_report(rev, trk_start[st], trk_next[st]));
                    trk_from[st] = trk_next[st] + 1;
                    trk_open[st] = 1'b0;
                end
            end
        end else if (s >= trk_from[st] && window_hit(len, rev)) begin
            trk_open[st]  = 1'b1;
            trk_start[st] = s;
            trk_next[st]  = s + len;
        end
    endtask

    task automatic predict_runs(t_base code, logic rec_end);
        int unsigned len;
        logic [31:0] p;
        t_run_report r;
        p   = base_pos;
        len = motif_span();
        fresh_runs.delete();
        for (int k = WIN_LIMIT - 1; k > 0; k--) begin
            win_hist[k] = win_hist[k-1];
        end
        win_hist[0] = code;
        // Nothing is tested until a whole motif has arrived in this record.
        if (len > 0 && p >= len - 1) begin
            track_strand(0, len, p);
            track_strand(1, len, p);
        end
        // The base is handled normally first, then the record end flushes
        // every open run, forward before reverse.
        if (rec_end) begin
            for (int st = 0; st < 2; st++) begin
                if (trk_open[st]) begin
                    fresh_runs.push_back(make_report(st != 0, trk_start[st], trk_next[st]));
                end
                trk_open[st] = 1'b0;
                trk_from[st] = '0;
            end
            base_pos = '0;
        end else begin
            base_pos = p + 1;
        end
        for (int i = 0; i < fresh_runs.size(); i++) begin
            r             = fresh_runs[i];
            r.last_result = (i == fresh_runs.size() - 1);
            runs_expected.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s at cycle %0d: expected %0h, got %0h",
                 what, cycle_count, want, got);
        errors++;
    endtask

    task automatic check_report();
        t_run_report want;
        if (runs_expected.size() == 0) begin
            flag_mismatch("report with nothing expected, run_start", '0, o_run_start);
            return;
        end
        want = runs_expected.pop_front();
        if (o_strand !== want.strand) begin
            flag_mismatch("strand", want.strand, o_strand);
        end
        if (o_run_start !== want.run_start) begin
            flag_mismatch("run_start", want.run_start, o_run_start);
        end
        if (o_run_end !== want.run_end) begin
            flag_mismatch("run_end", want.run_end, o_run_end);
        end
        if (o_run_length !== want.run_length) begin
            flag_mismatch("run_length", want.run_length, o_run_length);
        end
        if (o_last_result !== want.last_result) begin
            flag_mismatch("last_result", want.last_result, o_last_result);
        end
        reports_seen++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction. All of it runs in zero time, so the driver never
    // sees a record half built.
    // ------------------------------------------------------------------
    task automatic queue_base(t_base c, logic rec_end);
        t_base_item it;
        it.code    = c;
        it.rec_end = rec_end;
        base_queue.push_back(it);
    endtask

    // Appends keep bases of one motif copy, forward or reverse complement,
    // optionally with one base corrupted to break the run.
    task automatic put_copy(logic rev, int unsigned len, int unsigned keep, int flip_at);
        int unsigned idx;
        int unsigned flip;
        logic [1:0]  m;
        for (int i = 0; i < keep; i++) begin
            idx = rev ? (len - 1 - i) : i;
            m   = cfg_motif[2*idx +: 2];
            if (rev) begin
                m = 2'd3 - m;
            end
            if (i == flip_at) begin
                flip = $urandom_range(1, 3);
                m    = m + flip[1:0];
            end
            record_bases.push_back({1'b0, m});
        end
    endtask

    // Builds one record: mostly tandem copies of the motif or its reverse
    // complement, mixed with partial copies, corrupted copies, random bases
    // and non-ACGT codes. The last base carries the record end.
    task automatic build_record(int unsigned target);
        int unsigned len;
        int unsigned kind;
        len = motif_span();
        record_bases.delete();
        while (record_bases.size() < target) begin
            kind = $urandom_range(0, 9);
            if (len == 0 && kind < 7) begin
                kind = 8;
            end
            case (kind)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 4)) put_copy(1'b0, len, len, -1);
                end
                4, 5: begin
                    repeat ($urandom_range(1, 3)) put_copy(1'b1, len, len, -1);
                end
                6: begin
                    if ($urandom_range(0, 1) == 0) begin
                        put_copy($urandom_range(0, 1), len, $urandom_range(1, len), -1);
                    end else begin
                        put_copy($urandom_range(0, 1), len, len, $urandom_range(0, len - 1));
                    end
                end
                7: begin
                    record_bases.push_back(t_base'($urandom_range(4, 7)));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        record_bases.push_back(t_base'($urandom_range(0, 3)));
                    end
                end
            endcase
        end
        for (int i = 0; i < record_bases.size(); i++) begin
            queue_base(record_bases[i], i == record_bases.size() - 1);
        end
    endtask

    task automatic queue_random_records(int unsigned items);
        int unsigned start_size;
        start_size = base_queue.size();
        while (base_queue.size() - start_size < items) begin
            // Some very short records to exercise the start-of-record rule.
            if ($urandom_range(0, 7) == 0) begin
                build_record($urandom_range(1, 4));
            end else begin
                build_record($urandom_range(5, 48));
            end
        end
    endtask

    // Directed record under the reset motif TTAGGG: a leading other code, two
    // forward copies broken by the highest code, then two reverse complement
    // copies (CCCTAA) still open when the record ends.
    task automatic queue_directed();
        string       seq;
        t_base       c;
        seq = "NTTAGGGTTAGGGXCCCTAACCCTAA";
        for (int i = 0; i < seq.len(); i++) begin
            case (seq[i])
                "A":     c = 3'd0;
                "C":     c = 3'd1;
                "G":     c = 3'd2;
                "T":     c = 3'd3;
                "X":     c = 3'd7;
                default: c = 3'd4;
            endcase
            queue_base(c, i == seq.len() - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration writes, only issued while the block is idle.
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_reg idx, logic [MOTIF_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MOTIF_BASES) begin
            cfg_motif = data;
        end else begin
            cfg_length = data[LEN_BITS-1:0];
        end
    endtask

    // Waits until every queued base has transferred and every predicted report
    // has come back, then lets the pipe drain for bases that produced nothing.
    task automatic wait_idle();
        while (base_queue.size() != 0 || i_valid || runs_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: sends bases in bursts of random length separated by random
    // gaps. The payload holds while the block stalls, and the predictor runs
    // on every transfer.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        t_base_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_runs(i_base_code, i_record_end);
                bases_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (base_queue.size() > 0) begin
                    nxt = base_queue.pop_front();
                    i_valid      <= 1'b1;
                    i_base_code  <= nxt.code;
                    i_record_end <= nxt.rec_end;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every report transfer and drives the receiver stall.
    // The stall pattern rotates through four modes, chosen by cycle counter bits
    // 10:9: no stall, light random stall, long periodic stretches, heavy random stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_report();
            end
            case (cycle_count[10:9])
                2'd0:    i_stall <= 1'b0;
                2'd1:    i_stall <= ($urandom_range(0, 2) == 0);
                2'd2:    i_stall <= (cycle_count[5:4] == 2'b11);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Watchdog expired with %0d bases queued and %0d reports outstanding",
                     base_queue.size(), runs_expected.size());
            $display("tandem_motif_run_finder_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed record under the reset motif, then one
    // random phase per register setting. The settings cover the all-A and
    // all-T motifs, a self-complementary motif so both strands close on the
    // same base, random motifs, length zero, length one, sixteen, and a
    // length that saturates.
    // ------------------------------------------------------------------
    initial begin
        logic [MOTIF_BITS-1:0] ph_motif [PHASES];
        t_len                  ph_len   [PHASES];

        ph_motif[0] = 32'h0000_0000;  ph_len[0] = 5'd1;
        ph_motif[1] = 32'h0000_00E4;  ph_len[1] = 5'd4;   // ACGT
        ph_motif[2] = 32'hFFFF_FFFF;  ph_len[2] = 5'd16;
        ph_motif[3] = $urandom;       ph_len[3] = 5'd16;
        ph_motif[4] = $urandom;       ph_len[4] = t_len'($urandom_range(2, 15));
        ph_motif[5] = $urandom;       ph_len[5] = 5'd0;
        ph_motif[6] = $urandom;       ph_len[6] = 5'd31;
        ph_motif[7] = MOTIF_RESET;    ph_len[7] = LEN_RESET;

        base_pos = '0;
        for (int k = 0; k < WIN_LIMIT; k++) begin
            win_hist[k] = '0;
        end
        for (int st = 0; st < 2; st++) begin
            trk_open[st]  = 1'b0;
            trk_start[st] = '0;
            trk_next[st]  = '0;
            trk_from[st]  = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        queue_directed();
        queue_random_records(PHASE_ITEMS);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_MOTIF_BASES, ph_motif[ph]);
            write_reg(REG_MOTIF_LENGTH, {{(MOTIF_BITS-LEN_BITS){1'b0}}, ph_len[ph]});
            @(negedge i_clk);
            queue_random_records(PHASE_ITEMS);
            wait_idle();
        end

        if (runs_expected.size() != 0) begin
            flag_mismatch("reports never delivered", '0, runs_expected.size());
        end

        $display("Run covered %0d bases over %0d register settings with bursty input",
                 bases_sent, PHASES + 1);
        $display("and rotating receiver stalls; %0d run reports checked, %0d mismatches",
                 reports_seen, errors);
        if (errors == 0) begin
            $display("tandem_motif_run_finder_top verification clean");
        end else begin
            $display("tandem_motif_run_finder_top verification failed");
        end
        $finish;
    end

endmodule
